// ===== rtl/dtt_pkg.sv =====
// ============================================================================
// dtt_pkg
// Shared types and constants for the difficulty-to-target divider.
// ============================================================================
package dtt_pkg;

    // field widths
    localparam int DIFF_W       = 48;
    localparam int WORD_W       = 32;
    localparam int TARGET_WORDS = 8;
    localparam int IDX_W        = 3;

    // numerator is 0xffff placed at bit 208 + FRACTION_BITS
    localparam int FRACTION_BITS = 16;
    localparam int NUM_LOW_BIT   = 208 + FRACTION_BITS;
    localparam int NUM_ONES      = 16;

    // quotient bit counter
    localparam int QBITS = WORD_W * TARGET_WORDS;
    localparam int CNT_W = $clog2(QBITS);

    // index of the most significant word
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TARGET_WORDS - 1);

    // one queued job: divisor and its zero classification
    typedef struct packed {
        logic [DIFF_W-1:0] divisor;
        logic              zero;
    } job_t;

endpackage

// ===== rtl/dtt_front.sv =====
// ============================================================================
// dtt_front
// Accepts difficulty items, flags a zero divisor and holds jobs in a short
// queue until the divider takes them.
// ============================================================================
module dtt_front #(
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dtt_pkg::DIFF_W-1:0] difficulty,
    output logic                       job_valid,
    output dtt_pkg::job_t              job,
    input  logic                       job_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dtt_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;
    dtt_pkg::job_t    new_job;

    // classify the incoming item
    always_comb
    begin
        new_job.divisor = difficulty;
        new_job.zero    = (difficulty == '0);
    end

    assign in_ready  = (count_reg != FULL_CNT);
    assign push      = in_valid && in_ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ===== rtl/dtt_back.sv =====
// ============================================================================
// dtt_back
// Bit-serial restoring long division of the constant numerator by the
// difficulty, one quotient bit a cycle bar stalls, registered word output.
// ============================================================================
module dtt_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  dtt_pkg::job_t              job,
    output logic                       job_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dtt_pkg::WORD_W-1:0] target_word,
    output logic [dtt_pkg::IDX_W-1:0]  word_index,
    output logic                       last_word,
    output logic                       zero_difficulty
);

    localparam int D = dtt_pkg::DIFF_W;

    logic                       busy_reg;
    logic                       busy_next;
    logic [dtt_pkg::CNT_W-1:0]  bit_cnt_reg;
    logic [dtt_pkg::CNT_W-1:0]  bit_cnt_next;
    logic [D-1:0]               rem_reg;
    logic [D-1:0]               rem_next;
    logic [D-1:0]               divisor_reg;
    logic [dtt_pkg::WORD_W-1:0] qword_reg;
    logic [dtt_pkg::WORD_W-1:0] qword_shift;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [dtt_pkg::WORD_W-1:0] word_reg;
    logic [dtt_pkg::IDX_W-1:0]  idx_reg;
    logic                       last_reg;
    logic                       zero_reg;

    logic                       slot_free;
    logic                       word_end;
    logic                       step;
    logic                       num_bit;
    logic [D:0]                 trial;
    logic [D:0]                 diff;
    logic                       q_bit;
    logic                       load_word;
    logic                       load_zero;
    logic [dtt_pkg::CNT_W:0]    cnt_ext;

    assign slot_free = !out_valid_reg || out_ready;
    assign word_end  = (bit_cnt_reg[4:0] == '0);

    // a finished word may only advance into a free output slot
    assign step      = busy_reg && (!word_end || slot_free);
    assign job_pop   = !busy_reg && job_valid && (!job.zero || slot_free);
    assign load_zero = job_pop && job.zero;
    assign load_word = step && word_end;

    // numerator bit: a run of ones starting at the low bit
    assign cnt_ext = {1'b0, bit_cnt_reg};
    assign num_bit = (cnt_ext >= (dtt_pkg::CNT_W+1)'(dtt_pkg::NUM_LOW_BIT)) &&
                     (cnt_ext <  (dtt_pkg::CNT_W+1)'(dtt_pkg::NUM_LOW_BIT +
                                                     dtt_pkg::NUM_ONES));

    // one restoring division step
    assign trial       = {rem_reg, num_bit};
    assign diff        = trial - {1'b0, divisor_reg};
    assign q_bit       = (trial >= {1'b0, divisor_reg});
    assign qword_shift = {qword_reg[dtt_pkg::WORD_W-2:0], q_bit};

    always_comb
    begin
        busy_next    = busy_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        if (job_pop && !job.zero)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '1;
            rem_next     = '0;
        end
        else if (step)
        begin
            rem_next     = q_bit ? diff[D-1:0] : trial[D-1:0];
            bit_cnt_next = bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_word || load_zero)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (job_pop)
        begin
            divisor_reg <= job.divisor;
        end
        if (step)
        begin
            qword_reg <= qword_shift;
        end
        if (load_zero)
        begin
            word_reg <= '0;
            idx_reg  <= dtt_pkg::TOP_IDX;
            last_reg <= 1'b1;
            zero_reg <= 1'b1;
        end
        else if (load_word)
        begin
            word_reg <= qword_shift;
            idx_reg  <= bit_cnt_reg[dtt_pkg::CNT_W-1:5];
            last_reg <= (bit_cnt_reg == '0);
            zero_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_word     = word_reg;
    assign word_index      = idx_reg;
    assign last_word       = last_reg;
    assign zero_difficulty = zero_reg;

endmodule

// ===== rtl/difficulty_to_target_divider.sv =====
// The divide loop works one quotient bit per cycle over 256 quotient bits,
// pausing at a word boundary while the output slot is full, and takes a new
// item only once the current one is done. A zero difficulty gives one word.
// The output stalls the divider only at a word boundary.
// Reset: rst_n clears queue pointers, divider state and the output valid at once.
// ============================================================================
// difficulty_to_target_divider
// Turns a fixed-point mining difficulty into a 256-bit target, given out as
// eight 32-bit words, most significant first.
// ============================================================================
module difficulty_to_target_divider #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dtt_pkg::DIFF_W-1:0] difficulty,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dtt_pkg::WORD_W-1:0] target_word,
    output logic [dtt_pkg::IDX_W-1:0]  word_index,
    output logic                       last_word,
    output logic                       zero_difficulty
);

    logic          job_valid;
    logic          job_pop;
    dtt_pkg::job_t job;

    // front: accept, classify, queue
    dtt_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .difficulty(difficulty),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // back: long division and word output
    dtt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job            (job),
        .job_pop        (job_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .target_word    (target_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .zero_difficulty(zero_difficulty)
    );

endmodule

// ===== rtl/dtt_checker.sv =====
// ============================================================================
// dtt_checker
// Port-level checks on the divider's result stream.
// ============================================================================
module dtt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [dtt_pkg::WORD_W-1:0] target_word,
    input logic [dtt_pkg::IDX_W-1:0]  word_index,
    input logic                       last_word,
    input logic                       zero_difficulty
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_word) &&
        $stable(word_index) && $stable(last_word))
    else $error("stalled result item changed");

    // zero difficulty gives a single zero top word marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_difficulty |->
        last_word && target_word == '0 && word_index == dtt_pkg::TOP_IDX)
    else $error("malformed zero difficulty result");

    // the last word of a real target is word zero, and only it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_difficulty |-> last_word == (word_index == '0))
    else $error("last word mark out of place");

    // after an accepted non-final word, the next word shows one index lower
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word ##1 out_valid |->
        word_index == $past(word_index) - 1'b1)
    else $error("word index out of sequence");

endmodule

bind difficulty_to_target_divider dtt_checker u_dtt_checker (.*);

// ===== tb/tb_difficulty_to_target_divider.sv =====
// ============================================================================
// tb_difficulty_to_target_divider
// Self-checking testbench for the difficulty-to-target divider. Difficulties
// are pushed through the valid/ready input with random gaps. A long-division
// predictor works out the eight expected target words of each one, or the
// single flagged word of a zero difficulty. Every word taken from the output,
// under random back-pressure, is checked against the oldest expectation.
// ============================================================================
`timescale 1ns / 100ps

// expected words per difficulty, checked in order of arrival
class dtt_scoreboard;

    typedef struct {
        logic [dtt_pkg::WORD_W-1:0] word;
        logic [dtt_pkg::IDX_W-1:0]  idx;
        logic                       last;
        logic                       zero;
    } word_exp_t;

    word_exp_t words_due[$];
    int        errors;
    int        mismatches;
    int        n_items;
    int        n_zero;
    int        n_words;

    function new();
        errors     = 0;
        mismatches = 0;
        n_items    = 0;
        n_zero     = 0;
        n_words    = 0;
    endfunction

    // bit-serial long division of 0xffff << NUM_LOW_BIT by the raw difficulty
    function automatic logic [dtt_pkg::QBITS-1:0] target_of(
        input logic [dtt_pkg::DIFF_W-1:0] d);
        logic [dtt_pkg::DIFF_W:0]  rem;
        logic [dtt_pkg::QBITS-1:0] q;
        logic                      nbit;
        rem = '0;
        q   = '0;
        for (int b = dtt_pkg::QBITS - 1; b >= 0; b--)
        begin
            nbit = (b >= dtt_pkg::NUM_LOW_BIT) &&
                   (b < dtt_pkg::NUM_LOW_BIT + dtt_pkg::NUM_ONES);
            rem  = {rem[dtt_pkg::DIFF_W-1:0], nbit};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // an accepted difficulty: queue the words it should produce
    function void note_difficulty(input logic [dtt_pkg::DIFF_W-1:0] d);
        logic [dtt_pkg::QBITS-1:0] q;
        word_exp_t                 e;
        n_items++;
        if (d == '0)
        begin
            n_zero++;
            e.word = '0;
            e.idx  = dtt_pkg::TOP_IDX;
            e.last = 1'b1;
            e.zero = 1'b1;
            words_due.push_back(e);
        end
        else
        begin
            q = target_of(d);
            for (int k = 0; k < dtt_pkg::TARGET_WORDS; k++)
            begin
                e.idx  = dtt_pkg::IDX_W'(dtt_pkg::TARGET_WORDS - 1 - k);
                e.word = q[e.idx * dtt_pkg::WORD_W +: dtt_pkg::WORD_W];
                e.last = (k == dtt_pkg::TARGET_WORDS - 1);
                e.zero = 1'b0;
                words_due.push_back(e);
            end
        end
    endfunction

    // an accepted output word against the oldest expectation
    function void check_word(input logic [dtt_pkg::WORD_W-1:0] word,
                             input logic [dtt_pkg::IDX_W-1:0]  idx,
                             input logic                       last,
                             input logic                       zero);
        word_exp_t e;
        n_words++;
        if (words_due.size() == 0)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected word %h idx %0d last %b zero %b",
                         word, idx, last, zero);
            return;
        end
        e = words_due.pop_front();
        if (word !== e.word || idx !== e.idx || last !== e.last || zero !== e.zero)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: exp word %h idx %0d last %b zero %b, got %h %0d %b %b",
                         e.word, e.idx, e.last, e.zero, word, idx, last, zero);
        end
    endfunction

    function int pending();
        return words_due.size();
    endfunction

endclass

module tb_difficulty_to_target_divider;

    localparam int N_RANDOM     = 310;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1200000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [dtt_pkg::DIFF_W-1:0] difficulty;
    logic                       out_valid;
    logic                       out_ready;
    logic [dtt_pkg::WORD_W-1:0] target_word;
    logic [dtt_pkg::IDX_W-1:0]  word_index;
    logic                       last_word;
    logic                       zero_difficulty;

    dtt_scoreboard sb = new();
    int            cycles = 0;

    difficulty_to_target_divider i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .difficulty      (difficulty),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .target_word     (target_word),
        .word_index      (word_index),
        .last_word       (last_word),
        .zero_difficulty (zero_difficulty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout with %0d words outstanding", sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // random difficulty with a mix of shapes
    function automatic logic [dtt_pkg::DIFF_W-1:0] rand_difficulty();
        logic [63:0]                raw;
        logic [dtt_pkg::DIFF_W-1:0] d;
        int                         r;
        raw = {$urandom, $urandom};
        d   = raw[dtt_pkg::DIFF_W-1:0];
        r   = $urandom_range(0, 99);
        if (r < 5)
            d = '0;
        else if (r < 35)
            d = d;
        else if (r < 55)
            d = d >> $urandom_range(0, dtt_pkg::DIFF_W - 1);
        else if (r < 65)
            d = {{(dtt_pkg::DIFF_W-1){1'b0}}, 1'b1} << $urandom_range(0, dtt_pkg::DIFF_W - 1);
        else if (r < 75)
            d = dtt_pkg::DIFF_W'(48'h1_0000 + $urandom_range(0, 64) - 32);
        else if (r < 85)
            d = dtt_pkg::DIFF_W'($urandom_range(1, 65535));
        else
            d = ~({{(dtt_pkg::DIFF_W-1){1'b0}}, 1'b1} << $urandom_range(0, dtt_pkg::DIFF_W - 1))
                >> $urandom_range(0, 8);
        return d;
    endfunction

    // present one difficulty and hold it until accepted
    task automatic send_difficulty(input logic [dtt_pkg::DIFF_W-1:0] d);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        difficulty <= d;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_difficulty(d);
    endtask

    // hold the input off until every expected word is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // output side: bursts of ready with random stalls between
    initial
    begin
        int ready_left;
        int stall_left;
        ready_left = 0;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (ready_left == 0 && stall_left == 0)
            begin
                ready_left = $urandom_range(1, 24);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : idle_len();
                if ($urandom_range(0, 7) == 0)
                    ready_left = 200;
            end
            if (ready_left > 0)
            begin
                out_ready <= 1'b1;
                ready_left--;
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_word(target_word, word_index, last_word, zero_difficulty);
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [dtt_pkg::DIFF_W-1:0] directed [$];
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        difficulty <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, zero back to back, below one, exactly one, nominal constant
        directed = '{48'h0, 48'h0, 48'h1, 48'h2, 48'h3, 48'h8000, 48'hFFFF,
                     48'h1_0000, 48'h1_0001, 48'hFFFF_0000, 48'hFFFF_FFFF,
                     48'h1_0000_0000, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFE,
                     48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                     48'h1234_5678_9ABC, 48'h0, 48'h7, 48'hF_FFFF};
        foreach (directed[i])
            send_difficulty(directed[i]);
        wait_drained();

        // random part, with a full drain now and then
        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_difficulty(rand_difficulty());
            if (n % 60 == 59)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d difficulties (%0d zero) sent, %0d target words checked",
                 sb.n_items, sb.n_zero, sb.n_words);
        $display("summary: %0d mismatches in %0d cycles", sb.mismatches, cycles);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dtt_pkg.sv
rtl/dtt_front.sv
rtl/dtt_back.sv
rtl/difficulty_to_target_divider.sv
rtl/dtt_checker.sv
tb/tb_difficulty_to_target_divider.sv
